[rtl/single_wire_humidity_sensor_reader_core_defines.svh]
// Assertion macros shared by the single-wire humidity reader RTL.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_CORE_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SWHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SWHR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/swhr_pkg.sv]
// Shared types and constants for the single-wire humidity reader.
// No dependencies.
`default_nettype none

package swhr_pkg;

  localparam int unsigned BitsToReadDefault = 16;
  localparam int unsigned ShiftWidth        = 16;
  localparam int unsigned InDataWidth       = 8;
  localparam int unsigned OutDataWidth      = 24;
  localparam int unsigned CfgDataWidth      = 16;

  localparam logic [15:0] StartLowReset    = 16'd20000;
  localparam logic [7:0]  ReleaseWaitReset = 8'd20;
  localparam logic [7:0]  SampleDelayReset = 8'd19;
  localparam logic [7:0]  TimeoutReset     = 8'd254;

  typedef enum logic [1:0] {
    CFG_START_LOW    = 2'd0,
    CFG_RELEASE_WAIT = 2'd1,
    CFG_SAMPLE_DELAY = 2'd2,
    CFG_TIMEOUT      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_RESP = 2'd1,
    STATUS_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_START_LOW = 8'b0000_0010,
    PH_RELEASE   = 8'b0000_0100,
    PH_RESP_LOW  = 8'b0000_1000,
    PH_RESP_HIGH = 8'b0001_0000,
    PH_BIT_LOW   = 8'b0010_0000,
    PH_BIT_DELAY = 8'b0100_0000,
    PH_BIT_HIGH  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  release_wait_ticks;
    logic [7:0]  sample_delay_ticks;
    logic [7:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] second_byte;
    logic [7:0] first_byte;
    status_e    status;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } res_t;

endpackage

`default_nettype wire

[rtl/swhr_cfg_regs.sv]
// Configuration register file of the single-wire humidity reader.
// Depends on swhr_pkg.
`default_nettype none

module swhr_cfg_regs
  import swhr_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    wr_i,
  input  wire cfg_idx_e                idx_i,
  input  wire logic [CfgDataWidth-1:0] data_i,
  output cfg_t                         cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (idx_i)
        CFG_START_LOW:    cfg_d.start_low_ticks    = data_i;
        CFG_RELEASE_WAIT: cfg_d.release_wait_ticks = data_i[7:0];
        CFG_SAMPLE_DELAY: cfg_d.sample_delay_ticks = data_i[7:0];
        CFG_TIMEOUT:      cfg_d.timeout_ticks      = data_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks    <= StartLowReset;
      cfg_q.release_wait_ticks <= ReleaseWaitReset;
      cfg_q.sample_delay_ticks <= SampleDelayReset;
      cfg_q.timeout_ticks      <= TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/swhr_fsm.sv]
// Read sequencer: one tick of line sampling per step, state update and result.
// Depends on swhr_pkg and the assertion macro header.
`default_nettype none
`include "single_wire_humidity_sensor_reader_core_defines.svh"

module swhr_fsm
  import swhr_pkg::*;
#(
  parameter int unsigned BitsToRead = BitsToReadDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic line_i,
  input  wire logic start_i,
  input  wire cfg_t cfg_i,
  output res_t      res_o
);

  localparam int unsigned BcWidth = $clog2(BitsToRead + 1);

  phase_e                phase_q, phase_d;
  logic [15:0]           tick_q, tick_d;
  logic [BcWidth-1:0]    bits_q, bits_d;
  logic [ShiftWidth-1:0] shift_q, shift_d;
  status_e               held_q, held_d;
  logic                  done;
  logic [15:0]           tick_inc;
  logic                  wait_expired;

  assign tick_inc     = tick_q + 16'd1;
  assign wait_expired = tick_inc >= {8'd0, cfg_i.timeout_ticks};

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    held_d  = held_q;
    done    = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_START_LOW;
          tick_d  = '0;
          bits_d  = '0;
          shift_d = '0;
        end
      end
      PH_START_LOW: begin
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.start_low_ticks) begin
          phase_d = PH_RELEASE;
          tick_d  = '0;
        end
      end
      PH_RELEASE: begin
        tick_d = tick_inc;
        if (tick_inc >= {8'd0, cfg_i.release_wait_ticks}) begin
          tick_d = '0;
          if (line_i) begin
            phase_d = PH_IDLE;
            held_d  = STATUS_NO_RESP;
            done    = 1'b1;
          end else begin
            phase_d = PH_RESP_LOW;
          end
        end
      end
      PH_BIT_DELAY: begin
        tick_d = tick_inc;
        if (tick_inc >= {8'd0, cfg_i.sample_delay_ticks}) begin
          for (int i = 0; i < ShiftWidth; i++) begin
            if (line_i && (32'(bits_q) == 32'(ShiftWidth - 1 - i))) begin
              shift_d[i] = 1'b1;
            end
          end
          bits_d  = bits_q + BcWidth'(1);
          phase_d = PH_BIT_HIGH;
          tick_d  = '0;
        end
      end
      PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
        if (line_i == (phase_q == PH_RESP_LOW || phase_q == PH_BIT_LOW)) begin
          tick_d = '0;
          unique case (phase_q)
            PH_RESP_LOW:  phase_d = PH_RESP_HIGH;
            PH_RESP_HIGH: phase_d = PH_BIT_LOW;
            PH_BIT_LOW:   phase_d = PH_BIT_DELAY;
            default: begin
              if (32'(bits_q) >= BitsToRead) begin
                phase_d = PH_IDLE;
                held_d  = STATUS_OK;
                done    = 1'b1;
              end else begin
                phase_d = PH_BIT_LOW;
              end
            end
          endcase
        end else begin
          tick_d = tick_inc;
          if (wait_expired) begin
            phase_d = PH_IDLE;
            tick_d  = '0;
            held_d  = STATUS_TIMEOUT;
            done    = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      held_q  <= STATUS_OK;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      held_q  <= held_d;
    end
  end

  always_comb begin
    res_o.drive_low   = (phase_d == PH_START_LOW);
    res_o.busy_res    = (phase_d != PH_IDLE);
    res_o.done_res    = done;
    res_o.status      = held_d;
    res_o.first_byte  = shift_d[15:8];
    res_o.second_byte = shift_d[7:0];
  end

  `SWHR_ASSERT(a_phase_onehot, $onehot(phase_q), "phase register not one-hot")
  `SWHR_ASSERT(a_bits_bound, 32'(bits_q) <= BitsToRead, "bit count beyond read length")
  `SWHR_ASSERT(a_done_idle, step_i && done |=> phase_q == PH_IDLE && held_q == $past(held_d),
    "finished read did not return to idle with its status")

endmodule

`default_nettype wire

[rtl/swhr_out_buf.sv]
// Two-entry result buffer between the sequencer and the master stream side.
// Depends on swhr_pkg and the assertion macro header.
`default_nettype none
`include "single_wire_humidity_sensor_reader_core_defines.svh"

module swhr_out_buf
  import swhr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output logic      ready_o,
  output logic      valid_o,
  input  wire logic pop_ready_i,
  output res_t      data_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  `SWHR_ASSERT(a_no_overflow, push_i |-> ready_o, "push into full result buffer")
  `SWHR_ASSERT(a_count_ptrs, (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q),
    "buffer count disagrees with pointers")

endmodule

`default_nettype wire

[rtl/single_wire_humidity_sensor_reader_core.sv]
// Single-wire humidity sensor reader, host side.
// Top level; depends on swhr_pkg, swhr_cfg_regs, swhr_fsm and swhr_out_buf.
//
// Usage: every slave-side transaction is one time tick carrying the sampled
// wire level and a start request; every tick gives exactly one master-side
// transaction with the wire drive, busy, done, status and the received bytes.
// Present one tick per cycle for real-time operation.
// An accepted tick is registered in the input register, processed by the
// sequencer once the result buffer has room, and its result is pushed into
// the result buffer and offered on the master side from then on.
// Throughput: one tick per cycle while the result buffer has room; the read
// sequencer steps once per tick, between the input register and the two-entry buffer.
// A stalled master side fills the result buffer; once it holds two results
// and the input register is loaded, s_axis_tready_o drops until a result is
// taken. Nothing is lost or repeated.
// Configuration: write cfg_data_i to register cfg_index_i (0 start low ticks,
// 1 release wait, 2 sample delay, 3 timeout) while no read is in progress;
// cfg_ready_o is always high.
// Reset: sequencer idle, status ok, bytes zero, registers at their defaults,
// both streams empty.
`default_nettype none

module single_wire_humidity_sensor_reader_core
  import swhr_pkg::*;
#(
  parameter int unsigned BitsToRead = BitsToReadDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [0] line_level, [1] start_read, [7:2] zero
  input  wire logic [InDataWidth-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
  // [12:5] first_byte, [20:13] second_byte, [23:21] zero
  output logic [OutDataWidth-1:0]      m_axis_tdata_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [1:0]              cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  logic in_valid_q, in_valid_d;
  logic in_line_q, in_start_q;
  logic buf_ready, advance;
  cfg_t cfg;
  res_t res, res_out;

  assign cfg_ready_o     = 1'b1;
  assign advance         = in_valid_q && buf_ready;
  assign s_axis_tready_o = !in_valid_q || buf_ready;
  assign in_valid_d      = s_axis_tvalid_i || (in_valid_q && !buf_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_line_q  <= s_axis_tdata_i[0];
      in_start_q <= s_axis_tdata_i[1];
    end
  end

  swhr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i && cfg_ready_o),
    .idx_i  (cfg_idx_e'(cfg_index_i)),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  swhr_fsm #(
    .BitsToRead (BitsToRead)
  ) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .line_i  (in_line_q),
    .start_i (in_start_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  swhr_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (res_out)
  );

  assign m_axis_tdata_o = {3'b000, res_out};

endmodule

`default_nettype wire

[verif/swhr_readout_checker.sv]
// Checker for the single-wire humidity reader: mirrors its read sequence
// tick by tick and compares every result transaction. Depends on swhr_pkg.
module swhr_readout_checker
  import swhr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_valid_i,
  input  logic                    s_ready_i,
  input  logic [InDataWidth-1:0]  s_data_i,
  input  logic                    m_valid_i,
  input  logic                    m_ready_i,
  input  logic [OutDataWidth-1:0] m_data_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output int                      mismatches_o,
  output int                      awaited_o,
  output logic                    reader_idle_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] low_ticks_q;
  logic [7:0]  release_q;
  logic [7:0]  sample_q;
  logic [7:0]  timeout_q;

  phase_e      phase_q;
  logic [15:0] count_q;
  int unsigned bits_q;
  logic [15:0] bits_rx_q;
  status_e     status_q;

  res_t        awaited_readings[$];
  res_t        got;
  res_t        want;
  int          mismatches;

  function automatic res_t advance_reading(input logic line, input logic start);
    res_t        r;
    logic [15:0] next_count;
    logic        waiting;
    logic        ended;
    next_count = count_q + 16'd1;
    waiting    = 1'b0;
    ended      = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (start) begin
          phase_q   = PH_START_LOW;
          count_q   = '0;
          bits_q    = 0;
          bits_rx_q = '0;
        end
      end
      PH_START_LOW: begin
        count_q = next_count;
        if (next_count >= low_ticks_q) begin
          phase_q = PH_RELEASE;
          count_q = '0;
        end
      end
      PH_RELEASE: begin
        count_q = next_count;
        if (next_count >= {8'd0, release_q}) begin
          if (line) begin
            status_q = STATUS_NO_RESP;
            ended    = 1'b1;
          end else begin
            phase_q = PH_RESP_LOW;
            count_q = '0;
          end
        end
      end
      PH_RESP_LOW: begin
        if (line) begin
          phase_q = PH_RESP_HIGH;
          count_q = '0;
        end else begin
          waiting = 1'b1;
        end
      end
      PH_RESP_HIGH: begin
        if (!line) begin
          phase_q = PH_BIT_LOW;
          count_q = '0;
        end else begin
          waiting = 1'b1;
        end
      end
      PH_BIT_LOW: begin
        if (line) begin
          phase_q = PH_BIT_DELAY;
          count_q = '0;
        end else begin
          waiting = 1'b1;
        end
      end
      PH_BIT_DELAY: begin
        count_q = next_count;
        if (next_count >= {8'd0, sample_q}) begin
          if (bits_q < ShiftWidth && line) begin
            bits_rx_q[ShiftWidth - 1 - bits_q] = 1'b1;
          end
          if (bits_q < 63) begin
            bits_q++;
          end
          phase_q = PH_BIT_HIGH;
          count_q = '0;
        end
      end
      default: begin
        if (!line) begin
          if (bits_q >= BitsToReadDefault) begin
            status_q = STATUS_OK;
            ended    = 1'b1;
          end else begin
            phase_q = PH_BIT_LOW;
            count_q = '0;
          end
        end else begin
          waiting = 1'b1;
        end
      end
    endcase
    if (waiting) begin
      count_q = next_count;
      if (next_count >= {8'd0, timeout_q}) begin
        status_q = STATUS_TIMEOUT;
        ended    = 1'b1;
      end
    end
    if (ended) begin
      phase_q = PH_IDLE;
      count_q = '0;
    end
    r.drive_low   = (phase_q == PH_START_LOW);
    r.busy_res    = (phase_q != PH_IDLE);
    r.done_res    = ended;
    r.status      = status_q;
    r.first_byte  = bits_rx_q[15:8];
    r.second_byte = bits_rx_q[7:0];
    return r;
  endfunction

  task automatic compare_field(input string what, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_ticks_q = StartLowReset;
      release_q   = ReleaseWaitReset;
      sample_q    = SampleDelayReset;
      timeout_q   = TimeoutReset;
      phase_q     = PH_IDLE;
      count_q     = '0;
      bits_q      = 0;
      bits_rx_q   = '0;
      status_q    = STATUS_OK;
      mismatches  = 0;
      awaited_readings.delete();
      mismatches_o  <= 0;
      awaited_o     <= 0;
      reader_idle_o <= 1'b1;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_START_LOW:    low_ticks_q = cfg_data_i[15:0];
          CFG_RELEASE_WAIT: release_q   = cfg_data_i[7:0];
          CFG_SAMPLE_DELAY: sample_q    = cfg_data_i[7:0];
          default:          timeout_q   = cfg_data_i[7:0];
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        got = res_t'(m_data_i[$bits(res_t)-1:0]);
        if (awaited_readings.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
          mismatches++;
        end else begin
          want = awaited_readings.pop_front();
          compare_field("drive_low", want.drive_low, got.drive_low);
          compare_field("busy", want.busy_res, got.busy_res);
          compare_field("done", want.done_res, got.done_res);
          compare_field("status", int'(want.status), int'(got.status));
          compare_field("first_byte", want.first_byte, got.first_byte);
          compare_field("second_byte", want.second_byte, got.second_byte);
        end
      end
      if (s_valid_i && s_ready_i) begin
        awaited_readings.push_back(advance_reading(s_data_i[0], s_data_i[1]));
      end
      mismatches_o  <= mismatches;
      awaited_o     <= awaited_readings.size();
      reader_idle_o <= (phase_q == PH_IDLE);
    end
  end

endmodule

[verif/tb_single_wire_humidity_sensor_reader_core.sv]
// Testbench top for the single-wire humidity reader: plays the sensor wire
// tick by tick, stalls both streams at random and gives the verdict.
// Depends on swhr_pkg, the reader core and swhr_readout_checker.
module tb_single_wire_humidity_sensor_reader_core;
  timeunit 1ns;
  timeprecision 1ps;
  import swhr_pkg::*;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    s_valid   = 1'b0;
  logic [InDataWidth-1:0]  s_data    = '0;
  logic                    m_ready   = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [1:0]              cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data  = '0;
  logic                    s_ready;
  logic                    m_valid;
  logic [OutDataWidth-1:0] m_data;
  logic                    cfg_ready;
  int                      mismatches;
  int                      awaited;
  logic                    reader_idle;

  bit calm         = 1'b0;
  int sl_eff       = StartLowReset;
  int rw_eff       = ReleaseWaitReset;
  int sd_eff       = SampleDelayReset;
  int to_eff       = TimeoutReset;
  int ticks_sent   = 0;
  int reads_issued = 0;
  int settings     = 0;

  always #2 clk = ~clk;

  single_wire_humidity_sensor_reader_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  swhr_readout_checker readout_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_valid_i     (s_valid),
    .s_ready_i     (s_ready),
    .s_data_i      (s_data),
    .m_valid_i     (m_valid),
    .m_ready_i     (m_ready),
    .m_data_i      (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .awaited_o     (awaited),
    .reader_idle_o (reader_idle)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic stray_start();
    return ($urandom_range(0, 9) == 0);
  endfunction

  function automatic int eff(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  task automatic drain_results();
    s_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  task automatic send_tick(input logic line, input logic start);
    int gap;
    gap = pick_gap();
    if ($urandom_range(0, 299) == 0) begin
      drain_results();
    end else if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {{(InDataWidth-2){1'b0}}, start, line};
    do @(posedge clk); while (!s_ready);
    ticks_sent++;
  endtask

  // drive a constant wire until the reader is back to idle
  task automatic settle_reader();
    drain_results();
    while (!reader_idle) begin
      repeat (8) send_tick(1'b0, 1'b0);
      drain_results();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val, input logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataWidth'(val);
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input int sl, input int rw, input int sd, input int to);
    settle_reader();
    write_reg(CFG_START_LOW, sl, 1'b0);
    write_reg(CFG_RELEASE_WAIT, rw, 1'b0);
    write_reg(CFG_SAMPLE_DELAY, sd, 1'b0);
    write_reg(CFG_TIMEOUT, to, 1'b1);
    sl_eff = eff(sl);
    rw_eff = eff(rw);
    sd_eff = eff(sd);
    to_eff = eff(to);
    settings++;
  endtask

  // hold the opposite level, then give the edge; rarely hold past the timeout
  task automatic wait_level(input logic target, output logic lost);
    int r;
    int hold;
    r = $urandom_range(0, 199);
    if (r == 0) hold = to_eff;
    else if (r < 12) hold = $urandom_range(0, to_eff - 1);
    else hold = $urandom_range(0, (to_eff - 1 < 3) ? to_eff - 1 : 3);
    repeat (hold) send_tick(!target, stray_start());
    lost = (hold >= to_eff);
    if (!lost) send_tick(target, stray_start());
  endtask

  task automatic run_read();
    logic        lost;
    logic [15:0] word;
    word = 16'($urandom);
    reads_issued++;
    send_tick(1'($urandom), 1'b1);
    repeat (sl_eff) send_tick(1'($urandom), stray_start());
    repeat (rw_eff - 1) send_tick(1'($urandom), stray_start());
    if ($urandom_range(0, 11) == 0) begin
      send_tick(1'b1, stray_start());
      return;
    end
    send_tick(1'b0, stray_start());
    wait_level(1'b1, lost);
    if (lost) return;
    wait_level(1'b0, lost);
    if (lost) return;
    for (int i = 15; i >= 0; i--) begin
      wait_level(1'b1, lost);
      if (lost) return;
      repeat (sd_eff - 1) send_tick(1'($urandom), stray_start());
      send_tick(word[i], stray_start());
      wait_level(1'b0, lost);
      if (lost) return;
    end
  endtask

  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        m_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int target;
    int budget;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    settle_reader();
    write_reg(CFG_START_LOW, 1, 1'b1);
    sl_eff = 1;
    settings++;
    run_read();

    load_settings(1, 1, 1, 1);
    // no response from the sensor
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    // start while busy, then timeout on the response low
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    drain_results();
    // one bit received, then timeout on its high level
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    // new start clears the received bytes
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);

    target = ticks_sent + 950;
    while (ticks_sent < target) begin
      load_settings($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 5),
                    $urandom_range(1, 14));
      budget = ticks_sent + 160;
      while (ticks_sent < budget) begin
        calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0) begin
          send_tick(1'($urandom), 1'b1);
          repeat ($urandom_range(5, 40)) send_tick(1'($urandom), stray_start());
        end else begin
          run_read();
        end
        repeat ($urandom_range(0, 3)) send_tick(1'($urandom), 1'b0);
      end
    end

    load_settings(0, 0, 0, 0);
    repeat (3) run_read();
    load_settings(1, 255, 255, 255);
    calm = 1'b0;
    // longest release wait, then no response
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (254) send_tick(1'($urandom), 1'b0);
    send_tick(1'b1, 1'b0);
    load_settings(280, 3, 2, 5);
    calm = 1'b1;
    run_read();
    calm = 1'b0;
    settle_reader();

    $display("Covered %0d wire ticks, %0d read requests and %0d register settings,",
             ticks_sent, reads_issued, settings);
    $display("with completed, unanswered, timed-out and interrupted reads.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
